### rtl/rced_pkg.sv
// Shared types, constants and helper functions for the relative error derivative core.
`default_nettype none
package rced_pkg;

    localparam int XW = 20;                 // CORDIC x/y width, Q16
    localparam int ZW = 20;                 // CORDIC angle width, Q16
    localparam int TW = 25;                 // rounded wp*pos term width
    localparam int PW = 37;                 // speed times sin/cos product width
    localparam int SW = 27;                 // pre-saturation sum width
    localparam int QUEUE_DEPTH = 4;
    localparam int CORDIC_STAGES_DEF = 14;
    localparam int ATAN_LEN = 24;

    localparam logic signed [ZW-1:0] Q16_HALF_PI = ZW'(102944);
    localparam logic signed [ZW-1:0] Q16_PI      = ZW'(205887);
    localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(39797);

    typedef struct packed {
        logic signed [ZW-1:0] z;
        logic                 flip;
        logic signed [15:0]   vt;
        logic signed [15:0]   vp;
        logic signed [15:0]   dxd;
        logic signed [15:0]   dyd;
        logic signed [TW-1:0] wpy;
        logic signed [TW-1:0] wpx;
        logic signed [15:0]   rh;
        logic                 rh_sat;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic signed [15:0] v;
        logic               sat;
    } t_clip;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
        logic signed [ZW-1:0] r;
        case (idx)
            5'd0:  r = ZW'(51472);
            5'd1:  r = ZW'(30386);
            5'd2:  r = ZW'(16055);
            5'd3:  r = ZW'(8150);
            5'd4:  r = ZW'(4091);
            5'd5:  r = ZW'(2047);
            5'd6:  r = ZW'(1024);
            5'd7:  r = ZW'(512);
            5'd8:  r = ZW'(256);
            5'd9:  r = ZW'(128);
            5'd10: r = ZW'(64);
            5'd11: r = ZW'(32);
            5'd12: r = ZW'(16);
            5'd13: r = ZW'(8);
            5'd14: r = ZW'(4);
            5'd15: r = ZW'(2);
            5'd16: r = ZW'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_clip clip16(input logic signed [SW-1:0] v);
        t_clip r;
        if (v > SW'(32767)) begin
            r.v   = 16'sh7FFF;
            r.sat = 1'b1;
        end else if (v < -SW'(32768)) begin
            r.v   = 16'sh8000;
            r.sat = 1'b1;
        end else begin
            r.v   = v[15:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/rced_front.sv
// Front end: input register, angle reduction, turn-rate cross terms, heading rate.
`default_nettype none
module rced_front
    import rced_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [15:0] i_rel_x,
    input  wire logic signed [15:0] i_rel_y,
    input  wire logic signed [15:0] i_rel_heading,
    input  wire logic signed [15:0] i_tracker_speed,
    input  wire logic signed [15:0] i_tracker_turn_rate,
    input  wire logic signed [15:0] i_planner_speed,
    input  wire logic signed [15:0] i_planner_turn_rate,
    input  wire logic signed [15:0] i_dist_x,
    input  wire logic signed [15:0] i_dist_y,
    input  wire t_q_status          i_q_status,
    output logic                    o_push,
    output t_item                   o_item
);

    logic               r_valid;
    logic signed [15:0] r_px, r_py, r_th, r_vt, r_wt, r_vp, r_wp, r_dxd, r_dyd;

    logic                 accept;
    logic signed [ZW-1:0] z_raw;
    logic signed [32:0]   wp_e, px_e, py_e, pr_y, pr_x;
    logic signed [16:0]   rh_w;
    t_clip                rh_c;

    assign o_in_stall = r_valid && i_q_status.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_status.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_px  <= i_rel_x;
            r_py  <= i_rel_y;
            r_th  <= i_rel_heading;
            r_vt  <= i_tracker_speed;
            r_wt  <= i_tracker_turn_rate;
            r_vp  <= i_planner_speed;
            r_wp  <= i_planner_turn_rate;
            r_dxd <= i_dist_x;
            r_dyd <= i_dist_y;
        end
    end

    always_comb begin
        z_raw = {{(ZW-19){r_th[15]}}, r_th, 3'b000};
        wp_e  = 33'(r_wp);
        px_e  = 33'(r_px);
        py_e  = 33'(r_py);
        pr_y  = wp_e * py_e + 33'sd128;
        pr_x  = wp_e * px_e + 33'sd128;
        rh_w  = 17'(r_wt) - 17'(r_wp);
        rh_c  = clip16(SW'(rh_w));

        o_item = '0;
        if (z_raw > Q16_HALF_PI) begin
            o_item.z    = z_raw - Q16_PI;
            o_item.flip = 1'b1;
        end else if (z_raw < -Q16_HALF_PI) begin
            o_item.z    = z_raw + Q16_PI;
            o_item.flip = 1'b1;
        end else begin
            o_item.z    = z_raw;
            o_item.flip = 1'b0;
        end
        o_item.vt     = r_vt;
        o_item.vp     = r_vp;
        o_item.dxd    = r_dxd;
        o_item.dyd    = r_dyd;
        o_item.wpy    = pr_y[32:8];
        o_item.wpx    = pr_x[32:8];
        o_item.rh     = rh_c.v;
        o_item.rh_sat = rh_c.sat;
    end

endmodule
`default_nettype wire

### rtl/rced_queue.sv
// Small word queue between the front end and the CORDIC back end.
`default_nettype none
module rced_queue
    import rced_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output t_item      o_item,
    output t_q_status  o_status
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_item            r_mem [QUEUE_DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt, n_cnt;

    assign o_status.full  = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_item         = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule
`default_nettype wire

### rtl/rced_back.sv
// Back end: pipelined CORDIC, speed products, final sums, saturation and output register.
`default_nettype none
module rced_back
    import rced_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_item i_item,
    input  wire t_q_status i_q_status,
    output logic       o_pop,
    output logic       o_out_valid,
    input  wire logic  i_out_stall,
    output logic signed [15:0] o_rate_x,
    output logic signed [15:0] o_rate_y,
    output logic signed [15:0] o_rate_heading,
    output logic       o_saturated
);

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
        logic signed [15:0]   vt;
        logic signed [15:0]   vp;
        logic signed [15:0]   dxd;
        logic signed [15:0]   dyd;
        logic signed [TW-1:0] wpy;
        logic signed [TW-1:0] wpx;
        logic signed [15:0]   rh;
        logic                 rh_sat;
    } t_cs;

    typedef struct packed {
        logic signed [PW-1:0] pc;
        logic signed [PW-1:0] ps;
        logic signed [15:0]   vp;
        logic signed [15:0]   dxd;
        logic signed [15:0]   dyd;
        logic signed [TW-1:0] wpy;
        logic signed [TW-1:0] wpx;
        logic signed [15:0]   rh;
        logic                 rh_sat;
    } t_ms;

    t_cs  r_st [CORDIC_STAGES+1];
    logic r_sv [CORDIC_STAGES+1];
    t_ms  r_ms;
    logic r_mv;
    logic r_out_valid;
    logic signed [15:0] r_rate_x, r_rate_y, r_rate_heading;
    logic r_sat;

    logic adv;
    t_cs  st0;
    t_ms  ms_n;
    logic signed [XW:0]   ce, se;
    logic signed [PW-1:0] pcr, psr;
    logic signed [20:0]   vtc, vts;
    logic signed [SW-1:0] sx, sy;
    t_clip                cx, cy;

    assign adv   = !r_out_valid || !i_out_stall;
    assign o_pop = adv && !i_q_status.empty;

    always_comb begin
        st0        = '0;
        st0.x      = CORDIC_GAIN;
        st0.y      = '0;
        st0.z      = i_item.z;
        st0.flip   = i_item.flip;
        st0.vt     = i_item.vt;
        st0.vp     = i_item.vp;
        st0.dxd    = i_item.dxd;
        st0.dyd    = i_item.dyd;
        st0.wpy    = i_item.wpy;
        st0.wpx    = i_item.wpx;
        st0.rh     = i_item.rh;
        st0.rh_sat = i_item.rh_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (adv) begin
            r_sv[0] <= o_pop;
        end
        if (adv) begin
            r_st[0] <= st0;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        t_cs                  nx;
        logic signed [XW-1:0] xs, ys;
        always_comb begin
            xs = r_st[i].x >>> i;
            ys = r_st[i].y >>> i;
            nx = r_st[i];
            if (!r_st[i].z[ZW-1]) begin
                nx.x = r_st[i].x - ys;
                nx.y = r_st[i].y + xs;
                nx.z = r_st[i].z - atan_q16(5'(i));
            end else begin
                nx.x = r_st[i].x + ys;
                nx.y = r_st[i].y - xs;
                nx.z = r_st[i].z + atan_q16(5'(i));
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[i+1] <= 1'b0;
            end else if (adv) begin
                r_sv[i+1] <= r_sv[i];
            end
            if (adv) begin
                r_st[i+1] <= nx;
            end
        end
    end

    always_comb begin
        ce = r_st[CORDIC_STAGES].flip ? -(XW+1)'(r_st[CORDIC_STAGES].x)
                                      : (XW+1)'(r_st[CORDIC_STAGES].x);
        se = r_st[CORDIC_STAGES].flip ? -(XW+1)'(r_st[CORDIC_STAGES].y)
                                      : (XW+1)'(r_st[CORDIC_STAGES].y);
        ms_n        = '0;
        ms_n.pc     = PW'(r_st[CORDIC_STAGES].vt) * PW'(ce);
        ms_n.ps     = PW'(r_st[CORDIC_STAGES].vt) * PW'(se);
        ms_n.vp     = r_st[CORDIC_STAGES].vp;
        ms_n.dxd    = r_st[CORDIC_STAGES].dxd;
        ms_n.dyd    = r_st[CORDIC_STAGES].dyd;
        ms_n.wpy    = r_st[CORDIC_STAGES].wpy;
        ms_n.wpx    = r_st[CORDIC_STAGES].wpx;
        ms_n.rh     = r_st[CORDIC_STAGES].rh;
        ms_n.rh_sat = r_st[CORDIC_STAGES].rh_sat;
    end

    always_comb begin
        pcr = r_ms.pc + PW'(32768);
        psr = r_ms.ps + PW'(32768);
        vtc = pcr[PW-1:16];
        vts = psr[PW-1:16];
        sx  = SW'(vtc) - SW'(r_ms.vp) + SW'(r_ms.wpy) + SW'(r_ms.dxd);
        sy  = SW'(vts) - SW'(r_ms.wpx) + SW'(r_ms.dyd);
        cx  = clip16(sx);
        cy  = clip16(sy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_mv        <= r_sv[CORDIC_STAGES];
            r_out_valid <= r_mv;
        end
        if (adv) begin
            r_ms           <= ms_n;
            r_rate_x       <= cx.v;
            r_rate_y       <= cy.v;
            r_rate_heading <= r_ms.rh;
            r_sat          <= cx.sat | cy.sat | r_ms.rh_sat;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_rate_x       = r_rate_x;
    assign o_rate_y       = r_rate_y;
    assign o_rate_heading = r_rate_heading;
    assign o_saturated    = r_sat;

endmodule
`default_nettype wire

### rtl/relative_car_error_derivative_core.sv
// Top level of the relative pose-error derivative core.
//
// Input channel: i_in_valid / o_in_stall with nine Q8.8 / Q3.13 fields; a word
// is taken at a clock edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall with rate_x, rate_y, rate_heading
// (Q8.8, saturated) and the saturated flag; one output word per input word,
// in order.
// Throughput: one word per cycle when the receiver does not stall.
// Path: from acceptance to o_out_valid a word passes the queue, CORDIC entry,
// one register per CORDIC stage, the product register and the output
// register; the input register loads at the accepting edge. The CORDIC
// stage count sets the depth.
// A four-word queue sits between the front end and the CORDIC back end.
// When i_out_stall and o_out_valid are both high the back end pipeline holds;
// the queue keeps filling and o_in_stall rises only once the queue and input register are full.
// Reset (synchronous, active low) empties the queue and pipeline; no
// output word is valid afterward.
`default_nettype none
module relative_car_error_derivative_core
    import rced_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [15:0] i_rel_x,
    input  wire logic signed [15:0] i_rel_y,
    input  wire logic signed [15:0] i_rel_heading,
    input  wire logic signed [15:0] i_tracker_speed,
    input  wire logic signed [15:0] i_tracker_turn_rate,
    input  wire logic signed [15:0] i_planner_speed,
    input  wire logic signed [15:0] i_planner_turn_rate,
    input  wire logic signed [15:0] i_dist_x,
    input  wire logic signed [15:0] i_dist_y,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [15:0]      o_rate_x,
    output logic signed [15:0]      o_rate_y,
    output logic signed [15:0]      o_rate_heading,
    output logic                    o_saturated
);

    t_q_status q_status;
    t_item     push_item, pop_item;
    logic      push, pop;

    rced_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_rel_x             (i_rel_x),
        .i_rel_y             (i_rel_y),
        .i_rel_heading       (i_rel_heading),
        .i_tracker_speed     (i_tracker_speed),
        .i_tracker_turn_rate (i_tracker_turn_rate),
        .i_planner_speed     (i_planner_speed),
        .i_planner_turn_rate (i_planner_turn_rate),
        .i_dist_x            (i_dist_x),
        .i_dist_y            (i_dist_y),
        .i_q_status          (q_status),
        .o_push              (push),
        .o_item              (push_item)
    );

    rced_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (pop_item),
        .o_status (q_status)
    );

    rced_back #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (pop_item),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_rate_x       (o_rate_x),
        .o_rate_y       (o_rate_y),
        .o_rate_heading (o_rate_heading),
        .o_saturated    (o_saturated)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> !push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.empty |-> !pop)
        else $error("pop from empty queue");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> q_status.full)
        else $error("input stalled with queue space left");

    a_full_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_status.empty && push) |=> !q_status.empty)
        else $error("queue lost a pushed word");

endmodule
`default_nettype wire
